FILE: rtl/core/ghacc_pkg.sv
// Shared types and constants of the GHASH accumulator.
package ghacc_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
    localparam int HALF_BITS   = BLOCK_BITS / 2;

    // Degree of the highest low-order term of x^128 + x^7 + x^2 + x + 1.
    localparam int GF_TAIL_DEG = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = HALF_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_KEY_HI = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_KEY_LO = 1'b1;

    typedef logic [BLOCK_BITS-1:0] t_block;
    typedef logic [HALF_BITS-1:0]  t_half;

endpackage : ghacc_pkg

FILE: rtl/core/ghacc_gfmul.sv
// Combinational GF(2^128) multiplier in the bit-reflected GCM convention.
module ghacc_gfmul
    import ghacc_pkg::*;
(
    input  t_block i_x,
    input  t_block i_h,
    output t_block o_z
);

    localparam int PROD_W = 2 * BLOCK_BITS - 1;
    localparam int HIGH_W = PROD_W - BLOCK_BITS;
    localparam int FOLD_W = HIGH_W + GF_TAIL_DEG;
    localparam int OVF_W  = FOLD_W - BLOCK_BITS;

    logic [BLOCK_BITS-1:0] a;
    logic [BLOCK_BITS-1:0] b;
    logic [PROD_W-1:0]     prod;
    logic [FOLD_W-1:0]     hi_ext;
    logic [FOLD_W-1:0]     fold1;
    logic [BLOCK_BITS-1:0] ovf_ext;
    logic [BLOCK_BITS-1:0] fold2;
    logic [BLOCK_BITS-1:0] red;

    // Coefficient of x^k sits at bit (BLOCK_BITS-1-k) of the big-endian word.
    always_comb begin
        for (int k = 0; k < BLOCK_BITS; k++) begin
            a[k] = i_x[BLOCK_BITS-1-k];
            b[k] = i_h[BLOCK_BITS-1-k];
        end
    end

    // Carry-less product, one shifted partial product per bit of a.
    always_comb begin
        prod = '0;
        for (int i = 0; i < BLOCK_BITS; i++) begin
            if (a[i]) begin
                prod = prod ^ ({{(BLOCK_BITS-1){1'b0}}, b} << i);
            end
        end
    end

    // Two folds by x^7 + x^2 + x + 1; the second one cannot overflow.
    always_comb begin
        hi_ext  = {{GF_TAIL_DEG{1'b0}}, prod[PROD_W-1:BLOCK_BITS]};
        fold1   = hi_ext ^ (hi_ext << 1) ^ (hi_ext << 2) ^ (hi_ext << GF_TAIL_DEG);
        ovf_ext = {{(BLOCK_BITS-OVF_W){1'b0}}, fold1[FOLD_W-1:BLOCK_BITS]};
        fold2   = ovf_ext ^ (ovf_ext << 1) ^ (ovf_ext << 2) ^ (ovf_ext << GF_TAIL_DEG);
        red     = prod[BLOCK_BITS-1:0] ^ fold1[BLOCK_BITS-1:0] ^ fold2;
    end

    always_comb begin
        for (int k = 0; k < BLOCK_BITS; k++) begin
            o_z[BLOCK_BITS-1-k] = red[k];
        end
    end

endmodule : ghacc_gfmul

FILE: rtl/core/ghash_accumulator_core.sv
// Top level of the GHASH accumulator: key registers, pipeline and accumulator.
//
// The core computes the GCM GHASH update Y = (Y xor X) * H over GF(2^128) for
// one full 16-byte word X per handshake and returns the updated Y with every
// word. A word is taken into an input register; in the following stage the
// full field multiplication is done combinationally against the current
// accumulator and the product is written to the accumulator and to the
// output register at the same edge. Each word passes the input register and
// then the output register; a new word is accepted in every cycle unless the
// output stalls, the rate set by the combinational multiplier and the one-word
// accumulator loop. When the output is stalled the input register may still
// hold one further word, after which the input side stalls too. A set restart
// flag clears the accumulator before its word is absorbed. The hash subkey H
// is written as two 64-bit halves through the configuration port, index 0
// for the upper half and index 1 for the lower; it should only be changed
// while no word is in flight. Both halves and the accumulator reset to zero.
module ghash_accumulator_core
    import ghacc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_half                i_block_hi,
    input  t_half                i_block_lo,
    input  logic                 i_restart,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_half                o_digest_hi,
    output t_half                o_digest_lo
);

    // Hash subkey.
    t_half  r_key_hi;
    t_half  r_key_lo;

    // Input stage.
    logic   r_in_valid;
    t_block r_block;
    logic   r_restart;

    // Accumulator and output stage.
    t_block r_acc;
    logic   r_out_valid;
    t_block r_digest;

    logic   in_take;
    logic   advance;
    t_block mul_x;
    t_block product;

    // A word moves on when the output register is empty or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Restart drops the old accumulator before the word is folded in.
    assign mul_x = (r_restart ? '0 : r_acc) ^ r_block;

    ghacc_gfmul u_gfmul (
        .i_x (mul_x),
        .i_h ({r_key_hi, r_key_lo}),
        .o_z (product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HASH_KEY_HI: r_key_hi <= i_cfg_data;
                CFG_HASH_KEY_LO: r_key_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_block   <= {i_block_hi, i_block_lo};
            r_restart <= i_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_acc <= product;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_digest <= product;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_digest_hi = r_digest[BLOCK_BITS-1:HALF_BITS];
    assign o_digest_lo = r_digest[HALF_BITS-1:0];

`ifndef SYNTH
    // The result shown after a word moves on is the new accumulator.
    a_digest_is_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> ({o_digest_hi, o_digest_lo} == r_acc))
        else $error("digest differs from accumulator after update");

    // The accumulator changes only when a word moves on.
    a_acc_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_acc))
        else $error("accumulator changed without a word");

    // Input stalls only when both stages are full and the output is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without cause");
`endif

endmodule : ghash_accumulator_core

FILE: verif/ghash_digest_monitor.sv
// Watches the GHASH core's channels, predicts each digest and compares it with the one returned.
`timescale 1ns / 100ps

module ghash_digest_monitor
    import ghacc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_half                 i_block_hi,
    input  t_half                 i_block_lo,
    input  logic                  i_restart,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_half                 i_digest_hi,
    input  t_half                 i_digest_lo,
    output int                    o_fail_count,
    output int                    o_pending
);

    // Reduction term of the bit-reflected GCM polynomial, x^128 + x^7 + x^2 + x + 1.
    localparam t_block GCM_REDUCTION = {8'hE1, {(BLOCK_BITS - 8){1'b0}}};

    t_block hash_key     = '0;
    t_block running_hash = '0;
    t_block digest_queue[$];
    int     fail_count   = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = digest_queue.size();

    // Bit 127 of the vector is the first bit of the field element.
    function automatic t_block gf_multiply(t_block x, t_block h);
        t_block product;
        t_block v;
        product = '0;
        v       = h;
        for (int i = BLOCK_BITS - 1; i >= 0; i--) begin
            if (x[i]) begin
                product ^= v;
            end
            v = v[0] ? ((v >> 1) ^ GCM_REDUCTION) : (v >> 1);
        end
        return product;
    endfunction

    always @(posedge i_clk) begin : watch
        t_block want;
        t_block y;
        if (!i_rst_n) begin
            hash_key     = '0;
            running_hash = '0;
            digest_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HASH_KEY_HI) begin
                    hash_key[BLOCK_BITS-1:HALF_BITS] = i_cfg_data;
                end else if (i_cfg_index == CFG_HASH_KEY_LO) begin
                    hash_key[HALF_BITS-1:0] = i_cfg_data;
                end
            end

            // The result leaving now belongs to an older word, so it is checked first.
            if (i_out_valid && !i_out_stall) begin
                if (digest_queue.size() == 0) begin
                    $display("%0t: digest %h_%h returned with none expected",
                             $time, i_digest_hi, i_digest_lo);
                    fail_count++;
                end else begin
                    want = digest_queue.pop_front();
                    if (i_digest_hi !== want[BLOCK_BITS-1:HALF_BITS]) begin
                        $display("%0t: digest_hi expected %h, got %h",
                                 $time, want[BLOCK_BITS-1:HALF_BITS], i_digest_hi);
                        fail_count++;
                    end
                    if (i_digest_lo !== want[HALF_BITS-1:0]) begin
                        $display("%0t: digest_lo expected %h, got %h",
                                 $time, want[HALF_BITS-1:0], i_digest_lo);
                        fail_count++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                y            = i_restart ? '0 : running_hash;
                y            = y ^ {i_block_hi, i_block_lo};
                running_hash = gf_multiply(y, hash_key);
                digest_queue.push_back(running_hash);
            end
        end
    end

endmodule : ghash_digest_monitor

FILE: verif/ghash_accumulator_core_tb.sv
// Testbench top for the GHASH core: clock, reset, key writes, word traffic and the verdict.
`timescale 1ns / 100ps

module ghash_accumulator_core_tb
    import ghacc_pkg::*;
();

    // The limit lies well above what the slowest correct run needs.
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PHASES    = 6;
    localparam int WORDS_PER_PHASE  = 175;
    // The receiver holds off once for a long stretch after this many digests.
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 300;

    localparam t_half ALL_ONES = '1;
    localparam t_half TOP_BIT  = {1'b1, {(HALF_BITS - 1){1'b0}}};

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    t_half                 block_hi;
    t_half                 block_lo;
    logic                  restart;
    logic                  out_valid;
    logic                  out_stall;
    t_half                 digest_hi;
    t_half                 digest_lo;

    int fail_count;
    int pending;
    int cycle_count = 0;
    // While set, neither side draws a random gap, so the core runs at full rate outside the long hold-off.
    bit fast_mode   = 1'b0;

    ghash_accumulator_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_block_hi  (block_hi),
        .i_block_lo  (block_lo),
        .i_restart   (restart),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_digest_hi (digest_hi),
        .o_digest_lo (digest_lo)
    );

    ghash_digest_monitor digest_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_block_hi   (block_hi),
        .i_block_lo   (block_lo),
        .i_restart    (restart),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_digest_hi  (digest_hi),
        .i_digest_lo  (digest_lo),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // A hung handshake would otherwise leave the run going for ever.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one word, after a random gap unless the run is in a fast stretch, and returns
    // at the falling edge after it has been taken. Valid is left high so that a following
    // word without a gap follows on directly.
    task automatic send_word(input t_half hi, input t_half lo, input logic restart_flag);
        int gap;
        gap = fast_mode ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        block_hi <= hi;
        block_lo <= lo;
        restart  <= restart_flag;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Lets every word in flight come out, so that the core is idle for a key write.
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_hash_key(input t_half hi, input t_half lo);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HASH_KEY_HI;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_index <= CFG_HASH_KEY_LO;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly random halves, with the extremes and lone set bits mixed in.
    function automatic t_half pick_half();
        unique case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_ONES;
            2: return t_half'(1) << $urandom_range(0, HALF_BITS - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // The receiver draws a hold-off for each digest and then waits for the handshake. One
    // long hold-off lets the core fill up, so that its input side has to stall as well.
    initial begin : receiver
        int hold;
        int taken;
        taken     = 0;
        out_stall = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (taken == LONG_HOLD_AT) begin
                hold = LONG_HOLD_CYCLES;
            end else begin
                hold = fast_mode ? 0 : $urandom_range(0, 19);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
            @(negedge clk);
        end
    end

    initial begin : stimulus
        t_half key_hi;
        t_half key_lo;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_HASH_KEY_HI;
        cfg_data  = '0;
        in_valid  = 1'b0;
        block_hi  = '0;
        block_lo  = '0;
        restart   = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The key is still zero after reset, so every digest must come back as zero.
        send_word(ALL_ONES, ALL_ONES, 1'b0);
        send_word({$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_word(ALL_ONES, '0, 1'b1);
        drain_pipeline();

        // The unit element of the field: the first bit of the key only. The digest is then
        // simply the running XOR of the words, which shows the restart flag plainly.
        write_hash_key(TOP_BIT, '0);
        send_word('0, '0, 1'b1);
        send_word(ALL_ONES, ALL_ONES, 1'b0);
        send_word(TOP_BIT, t_half'(1), 1'b0);
        send_word(ALL_ONES, ALL_ONES, 1'b1);
        send_word('0, '0, 1'b0);
        drain_pipeline();

        // An all-ones key forces a reduction on each of the early shifts of the multiplication.
        write_hash_key(ALL_ONES, ALL_ONES);
        send_word(ALL_ONES, ALL_ONES, 1'b1);
        send_word('0, t_half'(1), 1'b0);
        send_word(TOP_BIT, '0, 1'b0);
        send_word('0, '0, 1'b0);
        send_word('0, '0, 1'b1);
        drain_pipeline();

        // Random phases, each under its own key. The accumulator is carried across the
        // key changes, since a phase only restarts where the random flag says so.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            unique case (p)
                1: begin
                    key_hi = '0;
                    key_lo = t_half'(1);
                end
                3: begin
                    key_hi = ALL_ONES;
                    key_lo = ALL_ONES;
                end
                4: begin
                    key_hi = '0;
                    key_lo = '0;
                end
                default: begin
                    key_hi = {$urandom, $urandom};
                    key_lo = {$urandom, $urandom};
                end
            endcase
            write_hash_key(key_hi, key_lo);
            fast_mode = (p == 2) || (p == 4);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_word(pick_half(), pick_half(), $urandom_range(0, 7) == 0);
            end
            drain_pipeline();
            fast_mode = 1'b0;
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule : ghash_accumulator_core_tb
